[sv/tcs_pkg.sv]
// shared types and constants for the text character scanout unit
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

  // default screen geometry
  localparam int unsigned COLS_DEF          = 64;
  localparam int unsigned TEXT_ROWS_DEF     = 32;
  localparam int unsigned SCANS_PER_ROW_DEF = 10;
  localparam int unsigned GLYPH_LINES_DEF   = 9;

  // item field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COLUMN_W   = 6;
  localparam int unsigned SCANLINE_W = 9;

  // stores
  localparam int unsigned VIDEO_AW    = 11;
  localparam int unsigned VIDEO_DEPTH = 1 << VIDEO_AW;
  localparam int unsigned GLYPH_AW    = 12;
  localparam int unsigned GLYPH_DEPTH = 1 << GLYPH_AW;
  localparam int unsigned GROW_W      = 4;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    OP_TICK   = 2'd0,
    OP_VWRITE = 2'd1,
    OP_GWRITE = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     data;
    logic [VIDEO_AW-1:0]   vaddr;
    logic [GROW_W-1:0]     glyph_row;
    logic                  blank;
    logic [COLUMN_W-1:0]   column;
    logic [SCANLINE_W-1:0] scanline;
    logic                  frame_end;
  } entry_t;

endpackage

`default_nettype wire

[sv/tcs_if.sv]
// request and result channel interfaces of the scanout unit
`timescale 1ns / 1ps
`default_nettype none

interface tcs_req_if;
  logic                       valid;
  logic                       ready;
  logic [tcs_pkg::REQ_W-1:0]  req_type;
  logic [tcs_pkg::ADDR_W-1:0] address;
  logic [tcs_pkg::DATA_W-1:0] data;

  modport source (output valid, req_type, address, data, input ready);
  modport sink   (input valid, req_type, address, data, output ready);
endinterface

interface tcs_res_if;
  logic                           valid;
  logic                           ready;
  logic [tcs_pkg::PIX_W-1:0]      pixels;
  logic [tcs_pkg::COLUMN_W-1:0]   column;
  logic [tcs_pkg::SCANLINE_W-1:0] scanline;
  logic                           frame_end;

  modport source (output valid, pixels, column, scanline, frame_end, input ready);
  modport sink   (input valid, pixels, column, scanline, frame_end, output ready);
endinterface

`default_nettype wire

[sv/tcs_front.sv]
// front end: takes items, tracks the raster position, builds queue entries
`timescale 1ns / 1ps
`default_nettype none

module tcs_front #(
  parameter int unsigned COLS          = tcs_pkg::COLS_DEF,
  parameter int unsigned TEXT_ROWS     = tcs_pkg::TEXT_ROWS_DEF,
  parameter int unsigned SCANS_PER_ROW = tcs_pkg::SCANS_PER_ROW_DEF,
  parameter int unsigned GLYPH_LINES   = tcs_pkg::GLYPH_LINES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  tcs_req_if.sink               req,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output tcs_pkg::entry_t       push_entry
);

  localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned RIC_W  = $clog2(SCANS_PER_ROW);
  localparam int unsigned ROW_W  = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
  localparam int unsigned LINE_W = $clog2(TEXT_ROWS * SCANS_PER_ROW);

  logic [COL_W-1:0]             col_count;
  logic [RIC_W-1:0]             row_in_char;
  logic [ROW_W-1:0]             char_row;
  logic [LINE_W-1:0]            line;
  logic [tcs_pkg::VIDEO_AW-1:0] vbase;

  logic is_tick, is_vwrite, is_gwrite, keep, acc_tick;
  logic last_col, last_scan, last_row;

  assign is_tick   = req.req_type == tcs_pkg::OP_TICK;
  assign is_vwrite = (req.req_type == tcs_pkg::OP_VWRITE) &&
                     (req.address[tcs_pkg::ADDR_W-1:tcs_pkg::VIDEO_AW] == '0);
  assign is_gwrite = req.req_type == tcs_pkg::OP_GWRITE;
  assign keep      = is_tick || is_vwrite || is_gwrite;

  assign req.ready  = push_ready;
  assign push_valid = req.valid && keep;
  assign acc_tick   = req.valid && push_ready && is_tick;

  assign last_col  = col_count == COL_W'(COLS - 1);
  assign last_scan = row_in_char == RIC_W'(SCANS_PER_ROW - 1);
  assign last_row  = char_row == ROW_W'(TEXT_ROWS - 1);

  always_comb begin
    push_entry           = '0;
    push_entry.op        = tcs_pkg::op_t'(req.req_type);
    push_entry.addr      = req.address;
    push_entry.data      = req.data;
    push_entry.vaddr     = vbase + tcs_pkg::VIDEO_AW'(col_count);
    push_entry.glyph_row = tcs_pkg::GROW_W'(row_in_char);
    push_entry.blank     = 32'(row_in_char) >= GLYPH_LINES;
    push_entry.column    = tcs_pkg::COLUMN_W'(col_count);
    push_entry.scanline  = tcs_pkg::SCANLINE_W'(line);
    push_entry.frame_end = last_col && last_scan && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_in_char <= '0;
      char_row    <= '0;
      line        <= '0;
      vbase       <= '0;
    end else if (acc_tick) begin
      if (!last_col) begin
        col_count <= col_count + 1'b1;
      end else begin
        col_count <= '0;
        if (!last_scan) begin
          row_in_char <= row_in_char + 1'b1;
          line        <= line + 1'b1;
        end else begin
          row_in_char <= '0;
          if (!last_row) begin
            char_row <= char_row + 1'b1;
            line     <= line + 1'b1;
            vbase    <= vbase + tcs_pkg::VIDEO_AW'(COLS);
          end else begin
            char_row <= '0;
            line     <= '0;
            vbase    <= '0;
          end
        end
      end
    end
  end

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (acc_tick && !last_col) |=> (col_count == $past(col_count) + 1'b1))
    else $error("column did not step");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (rst)
    (acc_tick && push_entry.frame_end) |=>
      (col_count == '0 && row_in_char == '0 && char_row == '0 && line == '0))
    else $error("raster did not wrap at frame end");

endmodule

`default_nettype wire

[sv/tcs_queue.sv]
// short entry queue between the front end and the store pipeline
`timescale 1ns / 1ps
`default_nettype none

module tcs_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire tcs_pkg::entry_t push_entry,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output tcs_pkg::entry_t      pop_entry
);

  tcs_pkg::entry_t              slots [tcs_pkg::QUEUE_DEPTH];
  logic [tcs_pkg::QPTR_W-1:0]   wptr, rptr;
  logic [tcs_pkg::QCNT_W-1:0]   count;
  logic                         do_push, do_pop;

  assign push_ready = count != tcs_pkg::QCNT_W'(tcs_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tcs_pkg::QCNT_W'(tcs_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[sv/tcs_back.sv]
// back end: video store, glyph store and the result register
`timescale 1ns / 1ps
`default_nettype none

module tcs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire tcs_pkg::entry_t pop_entry,
  tcs_res_if.source            res
);

  logic [tcs_pkg::DATA_W-1:0] video_mem [tcs_pkg::VIDEO_DEPTH];
  logic [tcs_pkg::DATA_W-1:0] glyph_mem [tcs_pkg::GLYPH_DEPTH];

  tcs_pkg::entry_t              s1, s2;
  logic                         s1_valid, s2_valid, res_valid, adv;
  logic [tcs_pkg::DATA_W-1:0]   code_rd, glyph_rd;
  logic [tcs_pkg::PIX_W-1:0]    pixels;
  logic [tcs_pkg::COLUMN_W-1:0] column;
  logic [tcs_pkg::SCANLINE_W-1:0] scanline;
  logic                         frame_end;

  assign adv       = !res_valid || res.ready;
  assign pop_ready = adv;

  assign res.valid     = res_valid;
  assign res.pixels    = pixels;
  assign res.column    = column;
  assign res.scanline  = scanline;
  assign res.frame_end = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid && (s2.op == tcs_pkg::OP_TICK);
    end
  end

  // character code read, video writes
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= pop_entry;
      if (pop_valid && pop_entry.op == tcs_pkg::OP_VWRITE) begin
        video_mem[pop_entry.addr[tcs_pkg::VIDEO_AW-1:0]] <= pop_entry.data;
      end
      code_rd <= video_mem[pop_entry.vaddr];
    end
  end

  // glyph line read, glyph writes
  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s1;
      if (s1_valid && s1.op == tcs_pkg::OP_GWRITE) begin
        glyph_mem[s1.addr] <= s1.data;
      end
      glyph_rd <= glyph_mem[{code_rd, s1.glyph_row}];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixels    <= s2.blank ? '0 : glyph_rd;
      column    <= s2.column;
      scanline  <= s2.scanline;
      frame_end <= s2.frame_end;
    end
  end

  a_blank_line: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2.op == tcs_pkg::OP_TICK && s2.blank) |=> (pixels == '0))
    else $error("blank scanline gave lit pixels");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2.op != tcs_pkg::OP_TICK) |=> !res_valid)
    else $error("write item produced a result");

endmodule

`default_nettype wire

[sv/text_mode_character_scanout_unit.sv]
// top level of the text-mode character scanout unit
//
// req channel: one item per handshake. req_type tick asks for the next
// 8-pixel group in raster order (column fastest, then scanline, then
// character row); the other codes write a byte into the video store or the
// glyph store. Video writes above the store depth and the unused code are
// dropped without a result. Writes give no result and leave the raster alone.
// res channel: one item per tick with the pixels (bit 7 leftmost), the
// character column, the screen scanline and a frame end flag.
// Throughput is one item per cycle for any mix of ticks and writes while res
// does not stall. A tick's result passes through the queue, the video store
// read, the glyph store read and the result register, each store having a
// registered read port.
// When res stalls, the store pipeline holds and the 4-entry queue fills;
// req.ready drops once the queue is full. Reset puts the raster at column 0,
// scanline 0 and empties the pipeline; store contents are kept as they are
// and must be written before they are shown.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_character_scanout_unit #(
  parameter int unsigned COLS          = tcs_pkg::COLS_DEF,
  parameter int unsigned TEXT_ROWS     = tcs_pkg::TEXT_ROWS_DEF,
  parameter int unsigned SCANS_PER_ROW = tcs_pkg::SCANS_PER_ROW_DEF,
  parameter int unsigned GLYPH_LINES   = tcs_pkg::GLYPH_LINES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tcs_req_if.sink   req,
  tcs_res_if.source res
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  tcs_pkg::entry_t push_entry, pop_entry;

  tcs_front #(
    .COLS          (COLS),
    .TEXT_ROWS     (TEXT_ROWS),
    .SCANS_PER_ROW (SCANS_PER_ROW),
    .GLYPH_LINES   (GLYPH_LINES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  tcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  tcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .res       (res)
  );

endmodule

`default_nettype wire

[dv/text_mode_character_scanout_unit_tb.sv]
// self-checking testbench for the text-mode character scanout unit
`timescale 1ns / 1ps

module text_mode_character_scanout_unit_tb;

  localparam int unsigned COLS          = tcs_pkg::COLS_DEF;
  localparam int unsigned TEXT_ROWS     = tcs_pkg::TEXT_ROWS_DEF;
  localparam int unsigned SCANS_PER_ROW = tcs_pkg::SCANS_PER_ROW_DEF;
  localparam int unsigned GLYPH_LINES   = tcs_pkg::GLYPH_LINES_DEF;
  localparam int unsigned REQ_W         = tcs_pkg::REQ_W;
  localparam int unsigned ADDR_W        = tcs_pkg::ADDR_W;
  localparam int unsigned DATA_W        = tcs_pkg::DATA_W;
  localparam int unsigned PIX_W         = tcs_pkg::PIX_W;
  localparam int unsigned COLUMN_W      = tcs_pkg::COLUMN_W;
  localparam int unsigned SCANLINE_W    = tcs_pkg::SCANLINE_W;
  localparam int unsigned VIDEO_AW      = tcs_pkg::VIDEO_AW;
  localparam int unsigned VIDEO_DEPTH   = tcs_pkg::VIDEO_DEPTH;
  localparam int unsigned GLYPH_AW      = tcs_pkg::GLYPH_AW;
  localparam int unsigned GLYPH_DEPTH   = tcs_pkg::GLYPH_DEPTH;
  localparam int unsigned GROW_W        = tcs_pkg::GROW_W;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned TOTAL_ITEMS   = 1050;
  localparam int unsigned IDLE_PCT      = 37;

  class scanout_scoreboard;
    typedef struct {
      logic [PIX_W-1:0]      pixels;
      logic [COLUMN_W-1:0]   column;
      logic [SCANLINE_W-1:0] scanline;
      logic                  frame_end;
    } pixel_group_t;

    bit [DATA_W-1:0] video_mem [VIDEO_DEPTH];
    bit [DATA_W-1:0] glyph_mem [GLYPH_DEPTH];
    bit [COLUMN_W-1:0] col;
    bit [GROW_W-1:0]   rin;
    bit [4:0]          crow;
    int unsigned       errors;
    pixel_group_t      groups_due [$];

    function logic [VIDEO_AW-1:0] video_addr();
      return VIDEO_AW'((crow * COLS + col) % VIDEO_DEPTH);
    endfunction

    function int unsigned pending();
      return groups_due.size();
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
      pixel_group_t g;
      int unsigned line;
      logic [DATA_W-1:0] code;
      bit last_col, last_scan, last_row;
      case (kind)
        tcs_pkg::OP_VWRITE: begin
          if (a < VIDEO_DEPTH) video_mem[a[VIDEO_AW-1:0]] = d;
        end
        tcs_pkg::OP_GWRITE: begin
          glyph_mem[a] = d;
        end
        tcs_pkg::OP_TICK: begin
          g.pixels = '0;
          if (rin < GLYPH_LINES) begin
            code = video_mem[video_addr()];
            g.pixels = glyph_mem[{code, rin}];
          end
          line = crow * SCANS_PER_ROW + rin;
          last_col  = (col + 1 >= COLS);
          last_scan = (rin + 1 >= SCANS_PER_ROW);
          last_row  = (crow + 1 >= TEXT_ROWS);
          g.column    = col;
          g.scanline  = line[SCANLINE_W-1:0];
          g.frame_end = last_col && last_scan && last_row;
          groups_due.push_back(g);
          if (!last_col) begin
            col++;
          end else begin
            col = '0;
            if (!last_scan) begin
              rin++;
            end else begin
              rin = '0;
              crow = last_row ? '0 : crow + 1'b1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_group(logic [PIX_W-1:0] pixels, logic [COLUMN_W-1:0] column,
                              logic [SCANLINE_W-1:0] scanline, logic frame_end);
      pixel_group_t g;
      if (groups_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %h col %0d line %0d",
                 $time, pixels, column, scanline);
        return;
      end
      g = groups_due.pop_front();
      if (pixels !== g.pixels) report("pixels", 32'(g.pixels), 32'(pixels));
      if (column !== g.column) report("column", 32'(g.column), 32'(column));
      if (scanline !== g.scanline) report("scanline", 32'(g.scanline), 32'(scanline));
      if (frame_end !== g.frame_end) report("frame_end", 32'(g.frame_end), 32'(frame_end));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;
  int unsigned quiet = 0;
  int unsigned sent = 0;
  bit video_filled [VIDEO_DEPTH];
  bit glyph_filled [GLYPH_DEPTH];
  scanout_scoreboard sb = new;

  tcs_req_if req_ch ();
  tcs_res_if res_ch ();

  text_mode_character_scanout_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_group(res_ch.pixels, res_ch.column, res_ch.scanline, res_ch.frame_end);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] d);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.address  <= a;
    req_ch.data     <= d;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    sb.note_request(kind, a, d);
    if (kind == tcs_pkg::OP_VWRITE && a < VIDEO_DEPTH) video_filled[a[VIDEO_AW-1:0]] = 1'b1;
    if (kind == tcs_pkg::OP_GWRITE) glyph_filled[a] = 1'b1;
  endtask

  // fills in whatever the next group reads before the tick goes out
  task automatic tick_group();
    logic [VIDEO_AW-1:0] va;
    logic [GLYPH_AW-1:0] ga;
    if (sb.rin < GLYPH_LINES) begin
      va = sb.video_addr();
      if (!video_filled[va])
        send_req(tcs_pkg::OP_VWRITE, {1'b0, va}, DATA_W'($urandom_range(0, 255)));
      ga = {sb.video_mem[va], sb.rin};
      if (!glyph_filled[ga])
        send_req(tcs_pkg::OP_GWRITE, ga, DATA_W'($urandom_range(0, 255)));
    end
    send_req(tcs_pkg::OP_TICK, ADDR_W'($urandom_range(0, 4095)),
             DATA_W'($urandom_range(0, 255)));
  endtask

  // half the writes land right where the raster is about to read
  task automatic random_write();
    logic [ADDR_W-1:0] a;
    logic [GROW_W-1:0] gr;
    logic [DATA_W-1:0] d;
    d  = DATA_W'($urandom_range(0, 255));
    gr = GROW_W'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 1) == 0) a = ADDR_W'($urandom_range(0, 4095));
      else a = {1'b0, sb.video_addr()} + ADDR_W'($urandom_range(0, 3));
      send_req(tcs_pkg::OP_VWRITE, a, d);
    end else begin
      if ($urandom_range(0, 1) == 0) a = ADDR_W'($urandom_range(0, 4095));
      else a = {sb.video_mem[sb.video_addr()], gr};
      send_req(tcs_pkg::OP_GWRITE, a, d);
    end
  endtask

  initial begin
    int unsigned r;
    rst             <= 1'b1;
    no_idle         <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= tcs_pkg::OP_TICK;
    req_ch.address  <= '0;
    req_ch.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ignored codes and write-then-read hazards
    send_req(tcs_pkg::OP_GWRITE, 12'd0, 8'hFF);
    send_req(tcs_pkg::OP_VWRITE, 12'd0, 8'h00);
    send_req(REQ_UNUSED, 12'd0, 8'hAA);
    send_req(tcs_pkg::OP_VWRITE, 12'd2048, 8'h01);
    send_req(tcs_pkg::OP_VWRITE, 12'd4095, 8'hFF);
    tick_group();
    send_req(tcs_pkg::OP_VWRITE, 12'd1, 8'hFF);
    send_req(tcs_pkg::OP_GWRITE, 12'd4080, 8'h80);
    tick_group();
    send_req(tcs_pkg::OP_GWRITE, 12'd4095, 8'h01);
    send_req(tcs_pkg::OP_VWRITE, 12'd2, 8'h00);
    send_req(tcs_pkg::OP_VWRITE, 12'd2, 8'hFF);
    tick_group();
    send_req(tcs_pkg::OP_VWRITE, 12'd3, 8'hFF);
    send_req(tcs_pkg::OP_GWRITE, 12'd4080, 8'h01);
    tick_group();
    send_req(REQ_UNUSED, 12'd4095, 8'hFF);
    send_req(tcs_pkg::OP_GWRITE, 12'd2048, 8'h5A);
    send_req(tcs_pkg::OP_VWRITE, 12'd2047, 8'h80);
    tick_group();
    tick_group();

    // random mix with a stretch of no idling in the middle
    while (sent < TOTAL_ITEMS) begin
      no_idle <= (sent >= 400) && (sent < 600);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        tick_group();
      end else if (r < 95) begin
        random_write();
      end else begin
        send_req(REQ_UNUSED, ADDR_W'($urandom_range(0, 4095)),
                 DATA_W'($urandom_range(0, 255)));
      end
    end
    no_idle      <= 1'b0;
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
